// ===== rtl/lps_pkg.sv =====
// Package for the loop path signature block.
// Holds field widths, the direction encoding constant, stage control structs
// and the decimal weight function. No dependencies.
`timescale 1ns / 1ps

package lps_pkg;

  localparam int DIR_W           = 3;
  localparam int LEN_W           = 4;
  localparam int SIG_W           = 28;
  localparam int NUM_STEP_INPUTS = 8;
  localparam int MAX_STEPS_DEF   = 8;

  // A direction and its opposite always sum to this code.
  localparam logic [DIR_W-1:0] OPPOSITE_SUM = 3'd7;

  typedef struct packed {
    logic load;
    logic zero_len;
  } stage_ctl_t;

  typedef struct packed {
    logic reversed;
    logic zero_len;
  } pick_t;

  // Ten to the power k, modulo two to the SIG_W.
  function automatic logic [SIG_W-1:0] dec_weight(input int k);
    logic [SIG_W-1:0] w;
    w = SIG_W'(1);
    for (int i = 0; i < k; i++) begin
      w = SIG_W'(w * SIG_W'(10));
    end
    return w;
  endfunction

endpackage

// ===== rtl/lps_if.sv =====
// Channel interfaces for the loop path signature block.
// The input channel carries one path, the output channel one signature.
// Depends on lps_pkg.
`timescale 1ns / 1ps

interface lps_in_if import lps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] path_length;
  logic [DIR_W-1:0] step_dir_0;
  logic [DIR_W-1:0] step_dir_1;
  logic [DIR_W-1:0] step_dir_2;
  logic [DIR_W-1:0] step_dir_3;
  logic [DIR_W-1:0] step_dir_4;
  logic [DIR_W-1:0] step_dir_5;
  logic [DIR_W-1:0] step_dir_6;
  logic [DIR_W-1:0] step_dir_7;

  modport source (
    output valid, path_length, step_dir_0, step_dir_1, step_dir_2, step_dir_3,
           step_dir_4, step_dir_5, step_dir_6, step_dir_7,
    input  ready
  );
  modport sink (
    input  valid, path_length, step_dir_0, step_dir_1, step_dir_2, step_dir_3,
           step_dir_4, step_dir_5, step_dir_6, step_dir_7,
    output ready
  );
endinterface

interface lps_out_if import lps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SIG_W-1:0] signature;
  logic                    reversed_canonical;
  logic                    invalid_length;

  modport source (
    output valid, signature, reversed_canonical, invalid_length,
    input  ready
  );
  modport sink (
    input  valid, signature, reversed_canonical, invalid_length,
    output ready
  );
endinterface

// ===== rtl/lps_lane.sv =====
// One rotation lane: builds the octal key of the forward and reversed path
// rotated to start at step LANE, and registers both.
// Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_lane import lps_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int LANE      = 0
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic [LEN_W-1:0]                    len_i,
  input  logic [MAX_STEPS-1:0][DIR_W-1:0]     dirs_i,
  output logic [DIR_W*MAX_STEPS-1:0]          fwd_key_o,
  output logic [DIR_W*MAX_STEPS-1:0]          rev_key_o
);

  localparam int KEY_W = DIR_W * MAX_STEPS;
  localparam int SUM_W = $clog2(2 * MAX_STEPS + 1);
  localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  logic [KEY_W-1:0] fwd_key_d, fwd_key_q;
  logic [KEY_W-1:0] rev_key_d, rev_key_q;

  // Octal digits compare in the same order as the decimal digits they
  // stand for, since every rotation has the same number of digits.
  always_comb begin
    logic [SUM_W-1:0] len_w;
    logic [SUM_W-1:0] pos;
    logic [SUM_W-1:0] mir;
    len_w     = SUM_W'(len_i);
    fwd_key_d = '0;
    rev_key_d = '0;
    for (int j = 0; j < MAX_STEPS; j++) begin
      pos = SUM_W'(j) + SUM_W'(LANE);
      if (pos >= len_w) begin
        pos = pos - len_w;
      end
      mir = len_w - SUM_W'(1) - pos;
      if (SUM_W'(j) < len_w) begin
        fwd_key_d[DIR_W*j +: DIR_W] = dirs_i[pos[IDX_W-1:0]];
        rev_key_d[DIR_W*j +: DIR_W] = OPPOSITE_SUM - dirs_i[mir[IDX_W-1:0]];
      end
    end
    // A lane past the path length takes no part in the minimum.
    if (!(SUM_W'(LANE) < len_w)) begin
      fwd_key_d = '1;
      rev_key_d = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fwd_key_q <= fwd_key_d;
      rev_key_q <= rev_key_d;
    end
  end

  assign fwd_key_o = fwd_key_q;
  assign rev_key_o = rev_key_q;

endmodule

// ===== rtl/lps_merge.sv =====
// Merging stage: minimum trees over the forward and reversed lane keys,
// then the choice between the two minima, registered.
// Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_merge import lps_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                                     clk_i,
  input  stage_ctl_t                               ctl_i,
  input  logic [MAX_STEPS-1:0][DIR_W*MAX_STEPS-1:0] fwd_keys_i,
  input  logic [MAX_STEPS-1:0][DIR_W*MAX_STEPS-1:0] rev_keys_i,
  output logic [DIR_W*MAX_STEPS-1:0]               key_o,
  output pick_t                                    pick_o
);

  localparam int KEY_W  = DIR_W * MAX_STEPS;
  localparam int LEAVES = 1 << $clog2(MAX_STEPS);
  localparam int NODES  = 2 * LEAVES - 1;

  logic [NODES-1:0][KEY_W-1:0] fnode;
  logic [NODES-1:0][KEY_W-1:0] rnode;
  logic [KEY_W-1:0]            key_d, key_q;
  pick_t                       pick_d, pick_q;

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < MAX_STEPS) begin
        fnode[LEAVES-1+i] = fwd_keys_i[i];
        rnode[LEAVES-1+i] = rev_keys_i[i];
      end else begin
        fnode[LEAVES-1+i] = '1;
        rnode[LEAVES-1+i] = '1;
      end
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      fnode[n] = (fnode[2*n+2] < fnode[2*n+1]) ? fnode[2*n+2] : fnode[2*n+1];
      rnode[n] = (rnode[2*n+2] < rnode[2*n+1]) ? rnode[2*n+2] : rnode[2*n+1];
    end
  end

  // A tie between the two minima counts as forward.
  always_comb begin
    pick_d.reversed = (rnode[0] < fnode[0]) && !ctl_i.zero_len;
    pick_d.zero_len = ctl_i.zero_len;
    key_d           = (rnode[0] < fnode[0]) ? rnode[0] : fnode[0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q  <= key_d;
      pick_q <= pick_d;
    end
  end

  assign key_o  = key_q;
  assign pick_o = pick_q;

endmodule

// ===== rtl/lps_encode.sv =====
// Output stage: turns the chosen octal key into its decimal value, applies
// the sign and the zero-length case, and holds the result.
// Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_encode import lps_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [DIR_W*MAX_STEPS-1:0] key_i,
  input  pick_t                      pick_i,
  output logic signed [SIG_W-1:0]    signature_o,
  output logic                       reversed_o,
  output logic                       invalid_o
);

  logic [SIG_W-1:0] sig_d, sig_q;
  logic             rev_q, inv_q;

  // The sum is kept modulo two to the SIG_W, which gives the wrapped
  // signed value directly.
  always_comb begin
    logic [SIG_W-1:0] acc;
    logic [SIG_W-1:0] term;
    acc = '0;
    for (int k = 0; k < MAX_STEPS; k++) begin
      term = SIG_W'(key_i[DIR_W*k +: DIR_W]) * dec_weight(k);
      acc  = acc + term;
    end
    if (pick_i.zero_len) begin
      sig_d = '0;
    end else if (pick_i.reversed) begin
      sig_d = SIG_W'(0) - acc;
    end else begin
      sig_d = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sig_q <= sig_d;
      rev_q <= pick_i.reversed;
      inv_q <= pick_i.zero_len;
    end
  end

  assign signature_o = $signed(sig_q);
  assign reversed_o  = rev_q;
  assign invalid_o   = inv_q;

endmodule

// ===== rtl/loop_path_signature.sv =====
// Top level of the loop path signature block: rotation lanes, merging stage
// and output stage, with the pipeline valid control.
// Depends on lps_pkg, lps_if, lps_lane, lps_merge and lps_encode.
//
//   Channel  Dir  Carries
//   path_i   in   path_length, step_dir_0 .. step_dir_7
//   sig_o    out  signature, reversed_canonical, invalid_length
//
// Three register stages: lane keys, merged minimum, decimal result. One path
// can enter in every cycle while sig_o does not stall. Reset clears the stage
// valid flags only. A stall on sig_o fills the stages from the back, and path_i
// drops ready only once all three hold a result.
`timescale 1ns / 1ps

module loop_path_signature import lps_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lps_in_if.sink     path_i,
  lps_out_if.source  sig_o
);

  localparam int KEY_W = DIR_W * MAX_STEPS;

  logic [NUM_STEP_INPUTS-1:0][DIR_W-1:0] in_dirs;
  logic [MAX_STEPS-1:0][DIR_W-1:0]       dirs;
  logic [LEN_W-1:0]                      len_sat;
  logic [MAX_STEPS-1:0][KEY_W-1:0]       fwd_keys;
  logic [MAX_STEPS-1:0][KEY_W-1:0]       rev_keys;
  logic [KEY_W-1:0]                      min_key;
  pick_t                                 pick;
  stage_ctl_t                            merge_ctl;

  logic v1_d, v1_q, v2_d, v2_q, v3_d, v3_q;
  logic zero1_q;
  logic ld1, ld2, ld3;

  assign in_dirs = {path_i.step_dir_7, path_i.step_dir_6, path_i.step_dir_5,
                    path_i.step_dir_4, path_i.step_dir_3, path_i.step_dir_2,
                    path_i.step_dir_1, path_i.step_dir_0};

  // Steps without an input field read as code zero.
  for (genvar i = 0; i < MAX_STEPS; i++) begin : g_dirs
    if (i < NUM_STEP_INPUTS) begin : g_field
      assign dirs[i] = in_dirs[i];
    end else begin : g_none
      assign dirs[i] = '0;
    end
  end

  assign len_sat = (path_i.path_length > LEN_W'(MAX_STEPS)) ? LEN_W'(MAX_STEPS)
                                                            : path_i.path_length;

  // Each stage loads when its content can move on or it is empty.
  assign ld3          = v2_q && (!v3_q || sig_o.ready);
  assign ld2          = v1_q && (!v2_q || ld3);
  assign path_i.ready = !v1_q || !v2_q || ld3;
  assign ld1          = path_i.valid && path_i.ready;

  always_comb begin
    v1_d = ld1 ? 1'b1 : (ld2 ? 1'b0 : v1_q);
    v2_d = ld2 ? 1'b1 : (ld3 ? 1'b0 : v2_q);
    v3_d = ld3 ? 1'b1 : ((sig_o.ready) ? 1'b0 : v3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      zero1_q <= (path_i.path_length == '0);
    end
  end

  for (genvar s = 0; s < MAX_STEPS; s++) begin : g_lane
    lps_lane #(
      .MAX_STEPS (MAX_STEPS),
      .LANE      (s)
    ) u_lane (
      .clk_i     (clk_i),
      .load_i    (ld1),
      .len_i     (len_sat),
      .dirs_i    (dirs),
      .fwd_key_o (fwd_keys[s]),
      .rev_key_o (rev_keys[s])
    );
  end

  assign merge_ctl.load     = ld2;
  assign merge_ctl.zero_len = zero1_q;

  lps_merge #(
    .MAX_STEPS (MAX_STEPS)
  ) u_merge (
    .clk_i      (clk_i),
    .ctl_i      (merge_ctl),
    .fwd_keys_i (fwd_keys),
    .rev_keys_i (rev_keys),
    .key_o      (min_key),
    .pick_o     (pick)
  );

  lps_encode #(
    .MAX_STEPS (MAX_STEPS)
  ) u_encode (
    .clk_i       (clk_i),
    .load_i      (ld3),
    .key_i       (min_key),
    .pick_i      (pick),
    .signature_o (sig_o.signature),
    .reversed_o  (sig_o.reversed_canonical),
    .invalid_o   (sig_o.invalid_length)
  );

  assign sig_o.valid = v3_q;

  // Ready drops only when every stage is full and the output is stalled.
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !path_i.ready |-> (v1_q && v2_q && v3_q && !sig_o.ready))
    else $error("input stalled while a stage was free");

  // A zero-length path gives a plain zero result.
  a_zero_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sig_o.valid && sig_o.invalid_length) |->
      (sig_o.signature == '0 && !sig_o.reversed_canonical))
    else $error("zero-length path gave a non-zero result");

  // A result leaving the output stage is replaced or the stage empties.
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sig_o.valid && sig_o.ready && !v2_q) |=> !sig_o.valid)
    else $error("output stage repeated a transaction");

  // A stage that loads must have had its source stage occupied.
  a_load_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld3 |-> $past(ld2, 1) || v2_q)
    else $error("merge stage moved on without a transaction");

endmodule

// ===== verif/loop_path_signature_tb.sv =====
// Self-checking testbench for loop_path_signature: a directed table, then random paths
// with idle bursts on both channels, each signature checked against the table or predictor.
// Depends on lps_pkg, lps_in_if, lps_out_if and the loop_path_signature RTL.
`timescale 1ns / 1ps

module loop_path_signature_tb;
  import lps_pkg::*;

  localparam int          RANDOM_PATHS = 1850;
  localparam int          QUIET_TAIL   = 200;
  localparam int          HOLD_AT      = 400;
  localparam int          DRAIN_AT     = 900;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          STUCK_LIMIT  = 2000;
  localparam int          SETTLE       = 8;
  localparam logic [DIR_W-1:0] DIR_POS_T = 3'd3;
  localparam logic [DIR_W-1:0] DIR_NEG_T = 3'd4;
  localparam logic [DIR_W-1:0] DIR_POS_X = 3'd0;
  localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd7;

  typedef struct packed {
    logic [LEN_W-1:0]                      len;
    logic [NUM_STEP_INPUTS-1:0][DIR_W-1:0] dirs;
  } path_t;

  typedef struct packed {
    logic [SIG_W-1:0] sig;
    logic             rev;
    logic             inv;
  } sig_res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lps_in_if  path_if ();
  lps_out_if sig_if ();

  loop_path_signature dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .path_i (path_if),
    .sig_o  (sig_if)
  );

  sig_res_t sig_expect_q[$];
  path_t    dir_paths[$];
  bit       dir_typed[$];
  sig_res_t dir_sigs[$];

  int errors        = 0;
  int paths_sent    = 0;
  int sigs_checked  = 0;
  int sigs_reversed = 0;
  int sigs_invalid  = 0;
  int send_idle_pct = 0;
  bit quiet_tail    = 1'b0;
  bit hold_req      = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Decimal reading of one rotation: the step at the start is the least significant digit.
  function automatic longint unsigned rotation_number(
    input logic [NUM_STEP_INPUTS-1:0][DIR_W-1:0] seq, input int unsigned n,
    input int unsigned start);
    longint unsigned acc;
    acc = 0;
    for (int k = int'(n) - 1; k >= 0; k--) begin
      acc = acc * 10 + seq[(k + start) % n];
    end
    return acc;
  endfunction

  function automatic sig_res_t predict_signature(input path_t p);
    sig_res_t                              r;
    int unsigned                           n;
    logic [NUM_STEP_INPUTS-1:0][DIR_W-1:0] back;
    longint unsigned                       best;
    longint unsigned                       val;
    bit                                    from_back;
    r = '0;
    if (p.len == '0) begin
      r.inv = 1'b1;
      return r;
    end
    n = (p.len > MAX_STEPS_DEF) ? MAX_STEPS_DEF : p.len;
    back = '0;
    for (int i = 0; i < int'(n); i++) begin
      back[i] = OPPOSITE_SUM - p.dirs[n - 1 - i];
    end
    best = rotation_number(p.dirs, n, 0);
    from_back = 1'b0;
    for (int s = 1; s < int'(n); s++) begin
      val = rotation_number(p.dirs, n, s);
      if (val < best) best = val;
    end
    // A reversed reading only wins when strictly smaller, so ties stay forward.
    for (int s = 0; s < int'(n); s++) begin
      val = rotation_number(back, n, s);
      if (val < best) begin
        best = val;
        from_back = 1'b1;
      end
    end
    r.sig = from_back ? SIG_W'(64'd0 - best) : SIG_W'(best);
    r.rev = from_back;
    return r;
  endfunction

  function automatic path_t random_path();
    path_t p;
    int    m;
    p.dirs = (NUM_STEP_INPUTS * DIR_W)'($urandom);
    p.len  = LEN_W'($urandom_range(1, MAX_STEPS_DEF));
    case ($urandom_range(0, 9))
      0: begin
        p.len = $urandom_range(0, 1) ? '0 : LEN_W'($urandom_range(MAX_STEPS_DEF + 1, 15));
      end
      1: begin
        // The second half mirrors the first with opposite codes, so the
        // reversed path reads the same as the forward one.
        m = $urandom_range(1, MAX_STEPS_DEF / 2);
        p.len = LEN_W'(2 * m);
        for (int i = 0; i < m; i++) begin
          p.dirs[m + i] = OPPOSITE_SUM - p.dirs[m - 1 - i];
        end
      end
      2: begin
        for (int i = 0; i < NUM_STEP_INPUTS; i++) begin
          p.dirs[i] = $urandom_range(0, 1) ? DIR_POS_T : DIR_NEG_T;
        end
      end
      3: begin
        for (int i = 0; i < NUM_STEP_INPUTS; i++) begin
          p.dirs[i] = $urandom_range(0, 1) ? DIR_POS_X : DIR_NEG_X;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic void add_row(input int len, input logic [23:0] dirs, input bit typed,
                                  input int sig, input bit rev, input bit inv);
    path_t    p;
    sig_res_t r;
    p.len  = LEN_W'(len);
    p.dirs = dirs;
    r.sig  = SIG_W'(sig);
    r.rev  = rev;
    r.inv  = inv;
    dir_paths.push_back(p);
    dir_typed.push_back(typed);
    dir_sigs.push_back(r);
  endfunction

  task automatic offer_path(input path_t p, input bit typed, input sig_res_t typed_sig);
    path_if.valid       <= 1'b1;
    path_if.path_length <= p.len;
    path_if.step_dir_0  <= p.dirs[0];
    path_if.step_dir_1  <= p.dirs[1];
    path_if.step_dir_2  <= p.dirs[2];
    path_if.step_dir_3  <= p.dirs[3];
    path_if.step_dir_4  <= p.dirs[4];
    path_if.step_dir_5  <= p.dirs[5];
    path_if.step_dir_6  <= p.dirs[6];
    path_if.step_dir_7  <= p.dirs[7];
    sig_expect_q.push_back(typed ? typed_sig : predict_signature(p));
    do @(posedge clk); while (!path_if.ready);
    paths_sent++;
    if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
      path_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    while (sig_expect_q.size() != 0) @(posedge clk);
  endtask

  // Path source.
  initial begin
    path_if.valid       <= 1'b0;
    path_if.path_length <= '0;
    path_if.step_dir_0  <= '0;
    path_if.step_dir_1  <= '0;
    path_if.step_dir_2  <= '0;
    path_if.step_dir_3  <= '0;
    path_if.step_dir_4  <= '0;
    path_if.step_dir_5  <= '0;
    path_if.step_dir_6  <= '0;
    path_if.step_dir_7  <= '0;

    //      len  steps 7..0      typed sig        rev  inv
    add_row(0,   24'o00000000,   1,    0,         0,   1);
    add_row(0,   24'o77777777,   1,    0,         0,   1);
    add_row(1,   24'o00000000,   1,    0,         0,   0);
    add_row(1,   24'o00000007,   1,    0,         1,   0);
    add_row(1,   24'o00000003,   1,    3,         0,   0);
    add_row(1,   24'o00000004,   1,    -3,        1,   0);
    add_row(2,   24'o00000070,   1,    7,         0,   0);
    add_row(2,   24'o00000033,   1,    33,        0,   0);
    add_row(2,   24'o00000044,   1,    -33,       1,   0);
    add_row(8,   24'o00000000,   1,    0,         0,   0);
    add_row(8,   24'o77777777,   1,    0,         1,   0);
    add_row(8,   24'o33333333,   1,    33333333,  0,   0);
    add_row(8,   24'o44444444,   1,    -33333333, 1,   0);
    add_row(9,   24'o44444444,   1,    -33333333, 1,   0);
    add_row(15,  24'o00000000,   1,    0,         0,   0);
    add_row(3,   24'o76543123,   0,    0,         0,   0);
    add_row(4,   24'o07654321,   0,    0,         0,   0);
    add_row(5,   24'o01234567,   0,    0,         0,   0);
    add_row(6,   24'o77520052,   0,    0,         0,   0);
    add_row(7,   24'o01234567,   0,    0,         0,   0);
    add_row(8,   24'o76543210,   0,    0,         0,   0);
    add_row(8,   24'o01234567,   0,    0,         0,   0);
    add_row(12,  24'o13572460,   0,    0,         0,   0);
    add_row(15,  24'o77777776,   0,    0,         0,   0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_paths.size(); i++) begin
      offer_path(dir_paths[i], dir_typed[i], dir_sigs[i]);
    end
    path_if.valid <= 1'b0;
    wait_for_drain();

    for (int i = 0; i < RANDOM_PATHS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: send_idle_pct = 0;
          1: send_idle_pct = 5;
          2: send_idle_pct = 25;
          default: send_idle_pct = 50;
        endcase
      end
      if (i == HOLD_AT) begin
        // Keep offering back to back while the sink holds off, so the pipe fills.
        hold_req = 1'b1;
        send_idle_pct = 0;
      end
      if (i == DRAIN_AT) begin
        path_if.valid <= 1'b0;
        wait_for_drain();
      end
      if (i == RANDOM_PATHS - QUIET_TAIL) quiet_tail = 1'b1;
      offer_path(random_path(), 1'b0, '0);
    end
    path_if.valid <= 1'b0;

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d paths (%0d from the directed table); %0d signatures checked,",
             paths_sent, dir_paths.size(), sigs_checked);
    $display("of which %0d reversed-canonical and %0d invalid-length; %0d errors.",
             sigs_reversed, sigs_invalid, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Signature sink: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    int seg_left;
    int stall_pct;
    stall_left = 0;
    hold_left  = 0;
    seg_left   = 0;
    stall_pct  = 0;
    sig_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(50, 300);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 5;
          2: stall_pct = 25;
          default: stall_pct = 50;
        endcase
      end
      seg_left--;
      if (!rst_n) begin
        sig_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        sig_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        sig_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 16) - 1;
        sig_if.ready <= 1'b0;
      end else begin
        sig_if.ready <= 1'b1;
      end
    end
  end

  // Checks every signature transaction against the oldest expectation.
  always @(posedge clk) begin
    sig_res_t want;
    if (rst_n && sig_if.valid && sig_if.ready) begin
      sigs_checked++;
      if (sig_if.reversed_canonical) sigs_reversed++;
      if (sig_if.invalid_length) sigs_invalid++;
      if (sig_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected signature %0d with nothing outstanding", $time,
                 $signed(sig_if.signature));
      end else begin
        want = sig_expect_q.pop_front();
        if (sig_if.signature !== want.sig) begin
          errors++;
          $display("%0t: signature expected %0d got %0d", $time, $signed(want.sig),
                   $signed(sig_if.signature));
        end
        if (sig_if.reversed_canonical !== want.rev) begin
          errors++;
          $display("%0t: reversed_canonical expected %0b got %0b", $time, want.rev,
                   sig_if.reversed_canonical);
        end
        if (sig_if.invalid_length !== want.inv) begin
          errors++;
          $display("%0t: invalid_length expected %0b got %0b", $time, want.inv,
                   sig_if.invalid_length);
        end
      end
    end
  end

  // Ends the run if neither channel completes a transaction for too long.
  always @(posedge clk) begin
    int stuck;
    if ((path_if.valid && path_if.ready) || (sig_if.valid && sig_if.ready)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d signatures outstanding", $time,
               stuck, sig_expect_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/lps_pkg.sv
rtl/lps_if.sv
rtl/lps_lane.sv
rtl/lps_merge.sv
rtl/lps_encode.sv
rtl/loop_path_signature.sv
verif/loop_path_signature_tb.sv
